// ----- hw/rtl/bdlp_pkg.sv -----
// Shared types and constants for the button debouncer with long-press detection.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bdlp_pkg;

  // event codes on the result stream
  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_LONG    = 2'd2
  } kind_t;

  // configuration register map
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 27;

  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS = 1'd1;

  localparam int DEBOUNCE_W   = 24;
  localparam int LONG_PRESS_W = 27;

  localparam logic [DEBOUNCE_W-1:0]   DEBOUNCE_RESET   = 24'd50000;
  localparam logic [LONG_PRESS_W-1:0] LONG_PRESS_RESET = 27'd1000000;

  // events one button raises for one sample
  typedef struct packed {
    logic edge_hit;    // stable level changed
    logic edge_press;  // the change was a press
    logic long_hit;    // long-press threshold reached
  } lane_evt_t;

endpackage

// ----- hw/rtl/bdlp_lane.sv -----
// Per-button debounce and long-press lane: holds the button state and
// decides its events for the current sample. Depends on bdlp_pkg.
`timescale 1ns / 1ps

module bdlp_lane import bdlp_pkg::*; #(
  parameter int STAMP_BITS = 48
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic                    lvl,
  input  logic                    vld,
  input  logic [STAMP_BITS-1:0]   now,
  input  logic [DEBOUNCE_W-1:0]   debounce,
  input  logic [LONG_PRESS_W-1:0] long_hold,
  output lane_evt_t               evt
);

  logic                  raw;
  logic                  stable;
  logic                  long_done;
  logic [STAMP_BITS-1:0] change_stamp;
  logic [STAMP_BITS-1:0] press_stamp;

  logic                  moved;
  logic                  settled;
  logic                  held;
  logic                  stable_next;
  logic [STAMP_BITS-1:0] since_change;
  logic [STAMP_BITS-1:0] since_press;

  // both elapsed times in parallel; a fresh stamp means zero elapsed
  always_comb begin
    moved        = vld && (lvl != raw);
    since_change = now - change_stamp;
    since_press  = now - press_stamp;
    settled      = moved ? (debounce == '0)
                         : (since_change >= STAMP_BITS'(debounce));
    evt.edge_hit   = vld && settled && (lvl != stable);
    evt.edge_press = evt.edge_hit && lvl;
    stable_next    = evt.edge_hit ? lvl : stable;
    held           = evt.edge_press ? (long_hold == '0)
                                    : (since_press >= STAMP_BITS'(long_hold));
    evt.long_hit   = vld && stable_next && (evt.edge_press || !long_done) && held;
  end

  // state update once the sample is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      raw          <= 1'b0;
      stable       <= 1'b0;
      long_done    <= 1'b0;
      change_stamp <= '0;
      press_stamp  <= '0;
    end else if (step) begin
      if (moved) begin
        raw          <= lvl;
        change_stamp <= now;
      end
      if (evt.edge_hit) begin
        stable <= lvl;
      end
      if (evt.edge_press) begin
        press_stamp <= now;
      end
      if (evt.long_hit) begin
        long_done <= 1'b1;
      end else if (evt.edge_press) begin
        long_done <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/bdlp_emitter.sv -----
// Event serializer: holds the events of one sample and sends them through
// the output register one per cycle unless m_tready stalls it, in button
// order, press before long press. Depends on bdlp_pkg.
`timescale 1ns / 1ps

module bdlp_emitter import bdlp_pkg::*; #(
  parameter int  NUM_BUTTONS = 2,
  localparam int IDX_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  lane_evt_t         evts [NUM_BUTTONS],
  output logic              idle,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [IDX_W-1:0]  m_index,
  output kind_t             m_kind,
  output logic              m_last
);

  localparam int SLOTS = 2 * NUM_BUTTONS;
  localparam int SEL_W = $clog2(SLOTS);

  // slot 2*i is the edge event of button i, slot 2*i+1 its long press
  logic [SLOTS-1:0]       pending;
  logic [NUM_BUTTONS-1:0] press;
  logic [SLOTS-1:0]       sel;
  logic [SEL_W-1:0]       sel_j;
  logic [SLOTS-1:0]       mask_in;
  logic [NUM_BUTTONS-1:0] press_in;
  logic [IDX_W-1:0]       sel_btn;
  logic                   found;
  logic                   pick;

  // flatten lane events into slots
  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      mask_in[2*i]   = evts[i].edge_hit;
      mask_in[2*i+1] = evts[i].long_hit;
      press_in[i]    = evts[i].edge_press;
    end
  end

  // lowest pending slot goes first
  always_comb begin
    sel   = '0;
    sel_j = '0;
    found = 1'b0;
    for (int j = 0; j < SLOTS; j++) begin
      if (pending[j] && !found) begin
        sel[j] = 1'b1;
        sel_j  = SEL_W'(j);
        found  = 1'b1;
      end
    end
    sel_btn = IDX_W'(sel_j >> 1);
  end

  assign idle = (pending == '0);
  assign pick = (!m_tvalid || m_tready) && !idle;

  // pending slots and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pending  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        pending <= mask_in;
      end else if (pick) begin
        pending <= pending & ~sel;
      end
      if (pick) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load) begin
      press <= press_in;
    end
    if (pick) begin
      m_index <= sel_btn;
      m_last  <= ((pending & ~sel) == '0);
      if (sel_j[0]) begin
        m_kind <= KIND_LONG;
      end else if (press[sel_btn]) begin
        m_kind <= KIND_PRESS;
      end else begin
        m_kind <= KIND_RELEASE;
      end
    end
  end

  // a new sample only lands on an empty queue
  a_load_empty: assert property (@(posedge clk) disable iff (rst)
    load |-> (pending == '0))
    else $error("event queue overwritten");

  // a non-final event in the output means more are queued
  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_last) |-> (pending != '0))
    else $error("event marked not last with nothing queued");

  // each send removes exactly one queued event
  a_one_removed: assert property (@(posedge clk) disable iff (rst)
    pick |=> ($countones(pending) == $countones($past(pending)) - 1))
    else $error("send did not retire exactly one event");

endmodule

// ----- hw/rtl/button_debounce_long_press.sv -----
// Button debouncer with long-press detection. Each input transaction is one
// sample (timestamp in microseconds, pressed levels, read-valid mask); the block
// answers with zero to 2*NUM_BUTTONS event transactions (press, release, long
// press), tlast on the last event of the sample. A sample is registered on
// entry and evaluated for all buttons together once the previous sample's
// events have left the event queue; its events then leave one per cycle
// while the output is not stalled, and samples without events flow at one
// per cycle. The event queue, which loads one sample and then drains one
// event per cycle while the output is ready, sets the rate.
// Timestamps subtract modulo 2^STAMP_BITS; reset clears all button state and
// loads the default hold times. Depends on bdlp_pkg, bdlp_lane and
// bdlp_emitter.
`timescale 1ns / 1ps

module button_debounce_long_press import bdlp_pkg::*; #(
  parameter int  NUM_BUTTONS = 2,
  parameter int  STAMP_BITS  = 48,
  localparam int IDX_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1,
  localparam int IN_W        = ((STAMP_BITS + 2 * NUM_BUTTONS + 7) / 8) * 8,
  localparam int OUT_W       = ((IDX_W + 7) / 8) * 8
) (
  input  logic                    clk,
  input  logic                    rst,
  // input samples
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // tdata: now_us, button_levels, button_valid (lowest bit first), zero padded
  input  logic [IN_W-1:0]         s_axis_tdata,
  // events
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // tdata: button_index, zero padded
  output logic [OUT_W-1:0]        m_axis_tdata,
  // tuser: event_kind
  output logic [1:0]              m_axis_tuser,
  output logic                    m_axis_tlast,
  // configuration writes
  input  logic                    cfg_we,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  logic [DEBOUNCE_W-1:0]   debounce;
  logic [LONG_PRESS_W-1:0] long_hold;

  logic                    in_full;
  logic [STAMP_BITS-1:0]   in_now;
  logic [NUM_BUTTONS-1:0]  in_levels;
  logic [NUM_BUTTONS-1:0]  in_mask;

  logic                    queue_idle;
  logic                    step;
  lane_evt_t               evts [NUM_BUTTONS];
  logic [IDX_W-1:0]        ev_index;
  kind_t                   ev_kind;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce  <= DEBOUNCE_RESET;
      long_hold <= LONG_PRESS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE:   debounce  <= cfg_data[DEBOUNCE_W-1:0];
        REG_LONG_PRESS: long_hold <= cfg_data[LONG_PRESS_W-1:0];
        default: ;
      endcase
    end
  end

  // input register, evaluated when the event queue is empty
  assign step          = in_full && queue_idle;
  assign s_axis_tready = !in_full || queue_idle;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_axis_tready) begin
      in_full <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_now    <= s_axis_tdata[STAMP_BITS-1:0];
      in_levels <= s_axis_tdata[STAMP_BITS +: NUM_BUTTONS];
      in_mask   <= s_axis_tdata[STAMP_BITS + NUM_BUTTONS +: NUM_BUTTONS];
    end
  end

  // one lane per button
  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    bdlp_lane #(
      .STAMP_BITS (STAMP_BITS)
    ) u_lane (
      .clk        (clk),
      .rst        (rst),
      .step       (step),
      .lvl        (in_levels[i]),
      .vld        (in_mask[i]),
      .now        (in_now),
      .debounce   (debounce),
      .long_hold  (long_hold),
      .evt        (evts[i])
    );
  end

  // event queue and output register
  bdlp_emitter #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_emitter (
    .clk      (clk),
    .rst      (rst),
    .load     (step),
    .evts     (evts),
    .idle     (queue_idle),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .m_index  (ev_index),
    .m_kind   (ev_kind),
    .m_last   (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_W'(ev_index);
  assign m_axis_tuser = ev_kind;

endmodule
